>>> sv/voxel_cell_triangle_counter_macros.svh
// Assertion macros used by the voxel cell triangle counter datapath RTL.
`ifndef VOXEL_CELL_TRIANGLE_COUNTER_MACROS_SVH
`define VOXEL_CELL_TRIANGLE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define VCTC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vctc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define VCTC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vctc: next-cycle check failed");

`endif

>>> sv/vctc_pkg.sv
// Shared constants, types and helpers of the voxel cell triangle counter.
`default_nettype none

package vctc_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;

  localparam int COORD_W    = 16;
  localparam int KEY_W      = 3 * COORD_W;
  localparam int COUNT_W    = 32;
  localparam int DISTINCT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch key, restart the scan
    logic scan;    // keep issuing table reads
    logic update;  // write the entry, load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // hit found or every occupied entry compared
    logic out_free;   // result register can take a new beat
  } stat_t;

  // saturating increment
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> sv/vctc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/vctc_ctrl.sv
// Sequencer of the counter: accept, scan the table, update and post the result.
`default_nettype none

module vctc_ctrl
  import vctc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output      logic  in_ready,
  input  wire stat_t stat,
  output      cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // no beat is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // wait until the result register is free
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/vctc_dpath.sv
// Datapath: key register, table scan and compare, counters and result register.
`default_nettype none
`include "voxel_cell_triangle_counter_macros.svh"

module vctc_dpath
  import vctc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output      stat_t                 stat,
  input  wire logic [COORD_W-1:0]    cell_x,
  input  wire logic [COORD_W-1:0]    cell_y,
  input  wire logic [COORD_W-1:0]    cell_z,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [COUNT_W-1:0]    cell_count,
  output      logic                  is_new,
  output      logic                  table_full,
  output      logic [DISTINCT_W-1:0] distinct_cells,
  output      logic [COUNT_W-1:0]    total_triangles
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = COUNT_W + KEY_W;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((33'd1 << COORD_BITS) - 33'd1);

  // search state
  logic [KEY_W-1:0]   key_q;
  logic [CNT_W-1:0]   scan_addr;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [COUNT_W-1:0] hit_count;

  // table occupancy and running total
  logic [CNT_W-1:0]   occupied;
  logic [CNT_W-1:0]   occupied_next;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] total_next;

  logic [KEY_W-1:0]   key_in;
  logic               issue;
  logic               match;
  logic               full;
  logic [COUNT_W-1:0] new_count;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign key_in = {cell_z & COORD_MASK, cell_y & COORD_MASK, cell_x & COORD_MASK};

  // entries 0..occupied-1 are live, so the scan stops at the fill count
  assign issue = cmd.scan && !hit_found && (scan_addr < occupied);
  assign match = rd_pend && !hit_found && (ram_rdata[KEY_W-1:0] == key_q);

  assign stat.scan_done = hit_found || (!rd_pend && (scan_addr >= occupied));
  assign stat.out_free  = !out_valid || out_ready;

  // update: hit bumps the entry, miss takes the next free slot unless the table is full
  assign full      = !hit_found && (occupied == CNT_W'(TABLE_ENTRIES));
  assign new_count = hit_found ? sat_inc(hit_count) : COUNT_W'(1);
  assign ram_we    = cmd.update && !full;
  assign ram_waddr = hit_found ? hit_idx : occupied[IDX_W-1:0];

  assign occupied_next = (cmd.update && !hit_found && !full) ? occupied + 1'b1 : occupied;
  assign total_next    = (cmd.update && !full) ? sat_inc(total) : total;

  // one table row holds {count, key}
  vctc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({new_count, key_q}),
    .re    (issue),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // scan pipeline: address issue, then compare in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.start) begin
      key_q     <= key_in;
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      hit_found <= 1'b0;
    end else begin
      rd_pend <= issue;
      rd_idx  <= scan_addr[IDX_W-1:0];
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (match) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_count <= ram_rdata[ENTRY_W-1:KEY_W];
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      total    <= '0;
    end else begin
      occupied <= occupied_next;
      total    <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cell_count      <= full ? '0 : new_count;
      is_new          <= !hit_found && !full;
      table_full      <= full;
      distinct_cells  <= DISTINCT_W'(occupied_next);
      total_triangles <= total_next;
    end
  end

  `VCTC_ASSERT_IMP(a_occ_bound, clk, rst, 1'b1, occupied <= CNT_W'(TABLE_ENTRIES))
  `VCTC_ASSERT_IMP(a_hit_live, clk, rst, hit_found, CNT_W'(hit_idx) < occupied)
  `VCTC_ASSERT_NXT(a_update_posts, clk, rst, cmd.update, out_valid)
  `VCTC_ASSERT_IMP(a_new_or_full, clk, rst, out_valid, !(is_new && table_full))

endmodule

`default_nettype wire

>>> sv/voxel_cell_triangle_counter.sv
// Top level of the voxel cell triangle counter: controller plus datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    cell_x, cell_y, cell_z
//   output   out        out_valid/out_ready  cell_count, is_new, table_full,
//                                            distinct_cells, total_triangles
//
// A miss goes through accept, one table read per occupied entry, a compare of
// the last read, a step to see the scan end, and the update (with an empty
// table only accept, scan end and update). A hit at entry k ends the scan once
// that entry matches. The table has a single read port, which sets the scan length.
// Reset empties the table at once through the fill count; no clearing pass.
// A new input beat is accepted while the last result still waits; the update
// holds until the result register is free.
`default_nettype none

module voxel_cell_triangle_counter
  import vctc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [COORD_W-1:0]    cell_x,
  input  wire logic [COORD_W-1:0]    cell_y,
  input  wire logic [COORD_W-1:0]    cell_z,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [COUNT_W-1:0]    cell_count,
  output      logic                  is_new,
  output      logic                  table_full,
  output      logic [DISTINCT_W-1:0] distinct_cells,
  output      logic [COUNT_W-1:0]    total_triangles
);

  cmd_t  cmd;
  stat_t stat;

  vctc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vctc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COORD_BITS    (COORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .cell_z          (cell_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_count      (cell_count),
    .is_new          (is_new),
    .table_full      (table_full),
    .distinct_cells  (distinct_cells),
    .total_triangles (total_triangles)
  );

endmodule

`default_nettype wire

>>> tb/sv/voxel_cell_triangle_counter_chk.sv
`timescale 1ns / 100ps
// Scoreboard for the voxel cell triangle counter: predicts every result beat and checks it.
module voxel_cell_triangle_counter_chk
  import vctc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COORD_W-1:0]    cell_x,
  input  logic [COORD_W-1:0]    cell_y,
  input  logic [COORD_W-1:0]    cell_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COUNT_W-1:0]    cell_count,
  input  logic                  is_new,
  input  logic                  table_full,
  input  logic [DISTINCT_W-1:0] distinct_cells,
  input  logic [COUNT_W-1:0]    total_triangles,
  output int                    err_count,
  output int                    pending
);

  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    logic                  fresh;
    logic                  full;
    logic [DISTINCT_W-1:0] distinct;
    logic [COUNT_W-1:0]    total;
  } cell_tally_t;

  // shadow copy of the cell table
  logic [KEY_W-1:0]   shadow_keys   [TABLE_ENTRIES];
  logic [COUNT_W-1:0] shadow_counts [TABLE_ENTRIES];
  logic               shadow_used   [TABLE_ENTRIES];
  int                 used_cells;
  logic [COUNT_W-1:0] tri_total;

  cell_tally_t tally_q[$];
  int          mismatches = 0;
  int          open_tallies = 0;

  assign err_count = mismatches;
  assign pending   = open_tallies;

  // Look the cell up, update the shadow table and return the result it should give.
  function automatic cell_tally_t tally_cell(input logic [COORD_W-1:0] x, y, z);
    logic [COORD_W-1:0] cmask;
    logic [KEY_W-1:0]   key;
    int                 hit_idx;
    int                 free_idx;
    cell_tally_t        t;
    cmask = (COORD_BITS >= COORD_W) ? '1 : COORD_W'((1 << COORD_BITS) - 1);
    key = {z & cmask, y & cmask, x & cmask};
    hit_idx = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_used[i]) begin
        if (hit_idx < 0 && shadow_keys[i] == key) hit_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    t = '0;
    if (hit_idx >= 0) begin
      if (shadow_counts[hit_idx] != COUNT_MAX) shadow_counts[hit_idx]++;
      t.count = shadow_counts[hit_idx];
      if (tri_total != COUNT_MAX) tri_total++;
    end else if (free_idx >= 0) begin
      // lowest free entry takes the new cell
      shadow_keys[free_idx]   = key;
      shadow_counts[free_idx] = 1;
      shadow_used[free_idx]   = 1'b1;
      used_cells++;
      t.count = 1;
      t.fresh = 1'b1;
      if (tri_total != COUNT_MAX) tri_total++;
    end else begin
      // no room: triangle dropped
      t.full = 1'b1;
    end
    t.distinct = DISTINCT_W'(used_cells);
    t.total    = tri_total;
    return t;
  endfunction

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want, got);
    if (got !== want) begin
      $display("%0t  %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare result beats first, then queue the prediction for a newly accepted beat.
  always @(posedge clk) begin : score
    cell_tally_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) shadow_used[i] = 1'b0;
      used_cells = 0;
      tri_total  = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (tally_q.size() == 0) begin
          $display("%0t  result beat mismatch: expected no beat, got cell_count %0d",
                   $time, cell_count);
          mismatches++;
        end else begin
          want = tally_q.pop_front();
          check_field("cell_count", want.count, cell_count);
          check_field("is_new", COUNT_W'(want.fresh), COUNT_W'(is_new));
          check_field("table_full", COUNT_W'(want.full), COUNT_W'(table_full));
          check_field("distinct_cells", COUNT_W'(want.distinct), COUNT_W'(distinct_cells));
          check_field("total_triangles", want.total, total_triangles);
        end
      end
      if (in_valid && in_ready) tally_q.push_back(tally_cell(cell_x, cell_y, cell_z));
      open_tallies = tally_q.size();
    end
  end

endmodule

>>> tb/sv/voxel_cell_triangle_counter_tb.sv
`timescale 1ns / 100ps
// Top of the voxel cell triangle counter testbench: clock, reset, stimulus and verdict.
module voxel_cell_triangle_counter_tb
  import vctc_pkg::*;
();

  localparam int RAND_CELLS = 1030;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [COORD_W-1:0]    cell_x;
  logic [COORD_W-1:0]    cell_y;
  logic [COORD_W-1:0]    cell_z;
  logic                  out_valid;
  logic                  out_ready;
  logic [COUNT_W-1:0]    cell_count;
  logic                  is_new;
  logic                  table_full;
  logic [DISTINCT_W-1:0] distinct_cells;
  logic [COUNT_W-1:0]    total_triangles;
  int                    err_count;
  int                    pending;

  // every key sent so far, for hits and near misses
  logic [KEY_W-1:0] sent_keys[$];

  voxel_cell_triangle_counter u_top (
    .clk, .rst, .in_valid, .in_ready, .cell_x, .cell_y, .cell_z,
    .out_valid, .out_ready, .cell_count, .is_new, .table_full,
    .distinct_cells, .total_triangles
  );

  voxel_cell_triangle_counter_chk u_chk (
    .clk, .rst, .in_valid, .in_ready, .cell_x, .cell_y, .cell_z,
    .out_valid, .out_ready, .cell_count, .is_new, .table_full,
    .distinct_cells, .total_triangles, .err_count, .pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance. Valid stays high for a following beat.
  task automatic send_cell(input logic [COORD_W-1:0] x, y, z);
    in_valid <= 1'b1;
    cell_x   <= x;
    cell_y   <= y;
    cell_z   <= z;
    sent_keys.push_back({z, y, x});
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: 16-bit stall mask replayed in turn, reshuffled now and then.
  initial begin : ready_gen
    logic [15:0] stall_mask;
    int          hold;
    out_ready  <= 1'b0;
    stall_mask = '1;
    hold       = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = '1;
          1:       stall_mask = 16'($urandom);
          2:       stall_mask = 16'($urandom & $urandom);
          default: stall_mask = 16'($urandom | $urandom);
        endcase
        if (stall_mask == '0) stall_mask = 16'h0001;
        hold = $urandom_range(32, 256);
      end
      out_ready <= stall_mask[hold[3:0]];
      hold--;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    int               burst_left;
    int               pick;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    cell_x   <= '0;
    cell_y   <= '0;
    cell_z   <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corner coordinates, single-axis keys, back-to-back repeats
    send_cell(16'h0000, 16'h0000, 16'h0000);
    send_cell(16'h0000, 16'h0000, 16'h0000);
    send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cell(16'hFFFF, 16'h0000, 16'h0000);
    send_cell(16'h0000, 16'hFFFF, 16'h0000);
    send_cell(16'h0000, 16'h0000, 16'hFFFF);
    send_cell(16'h0001, 16'h0000, 16'h0000);
    send_cell(16'h0000, 16'h0001, 16'h0000);
    send_cell(16'h0000, 16'h0000, 16'h0001);
    send_cell(16'hAAAA, 16'h5555, 16'hAAAA);
    send_cell(16'h5555, 16'hAAAA, 16'h5555);
    send_cell(16'h8000, 16'h8000, 16'h8000);
    send_cell(16'h8000, 16'h8000, 16'h8000);
    send_cell(16'h8000, 16'h8000, 16'h8000);
    send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cell(16'h0000, 16'h0000, 16'h0000);
    send_cell(16'h1234, 16'h5678, 16'h9ABC);
    send_cell(16'h1234, 16'h5678, 16'h9ABC);
    drain_results();

    // Random: mostly hot cells, plus fresh and one-bit-off keys; the table
    // fills partway through, after which misses are dropped as table full.
    burst_left = 0;
    for (int n = 0; n < RAND_CELLS; n++) begin
      if (n == RAND_CELLS / 3 || n == 2 * RAND_CELLS / 3) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
      end
      pick = $urandom_range(0, 99);
      if (pick < 50)
        key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      else if (pick < 58)
        key = sent_keys[sent_keys.size() - 1];
      else if (pick < 70)
        key = sent_keys[$urandom_range(0, sent_keys.size() - 1)]
              ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
      else
        key = KEY_W'({$urandom, $urandom});
      send_cell(key[15:0], key[31:16], key[47:32]);
      burst_left--;
    end

    drain_results();
    // wait on to catch any stray beat
    repeat (300) @(negedge clk);
    if (err_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
